// File: hdl/ils_pkg.sv
// Shared types and codes for the indexed list store.
package ils_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int OP_W       = 2;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic                  from_end;
    logic [INDEX_W-1:0]    index;
    logic [WORD_WIDTH-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [WORD_WIDTH-1:0] data_out;
    logic [COUNT_W-1:0]    count;
  } rsp_t;

endpackage

// File: hdl/ils_ram.sv
// Element storage: one write port, one read port with registered read data.
module ils_ram #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 wen,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [ils_pkg::WORD_WIDTH-1:0]       wdata,
  input  logic                                 ren,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [ils_pkg::WORD_WIDTH-1:0]       rdata
);
  import ils_pkg::*;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/indexed_list_store_top.sv
// Indexed list store: ordered word list with insert, append, read and remove.
//
//   channel   signals              transfer when
//   request   start, busy, req     start high and busy low at a rising edge
//   result    done, rsp            done high; shown for one cycle only
//
// A sequencer moves one element at a time through the single RAM port pair
// (read, then write), so how long a request takes is set by how many elements shift.
// Reset clears the sequencer and the count; the stored words are not cleared.
// The receiver cannot stall: each result is taken in the cycle it is shown.
module indexed_list_store_top #(
  parameter int CAPACITY = 64  // 2 up to 64, the reach of index and count
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ils_pkg::req_t req,
  output logic          done,
  output ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_RD_ADDR,
    S_RD_DATA,
    S_MV_RD,
    S_MV_WR,
    S_PUT,
    S_RESP
  } state_t;

  state_t                state;
  req_t                  cur;
  logic [CW-1:0]         cnt;
  logic [PW-1:0]         pos;
  logic [PW-1:0]         ptr;
  logic [STATUS_W-1:0]   status;
  logic [WORD_WIDTH-1:0] result;

  logic                  wen;
  logic                  ren;
  logic [PW-1:0]         waddr;
  logic [PW-1:0]         raddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [WORD_WIDTH-1:0] rdata;

  logic [COUNT_W-1:0]    cnt_w;
  logic [COUNT_W-1:0]    idx_w;
  logic [COUNT_W-1:0]    tail_pos;
  logic [PW-1:0]         loc_pos;
  logic [PW-1:0]         dst;
  logic                  in_range;
  logic                  empty_head;
  logic                  full;
  logic                  ptr_last;
  logic                  pos_has_succ;

  always_comb begin
    cnt_w        = COUNT_W'(cnt);
    idx_w        = COUNT_W'(cur.index);
    in_range     = idx_w < cnt_w;
    empty_head   = (cur.index == '0) && (cnt == '0);
    full         = cnt == CW'(CAPACITY);
    // count - 1 - index in one add
    tail_pos     = cnt_w + ~idx_w;
    loc_pos      = cur.from_end ? tail_pos[PW-1:0] : idx_w[PW-1:0];
    ptr_last     = (COUNT_W'(ptr) + COUNT_W'(1)) == cnt_w;
    pos_has_succ = (COUNT_W'(pos) + COUNT_W'(1)) < cnt_w;
    // remove shifts down, insert shifts up
    dst          = (cur.op == OP_REMOVE) ? ptr - PW'(1) : ptr + PW'(1);
  end

  always_comb begin
    ren   = (state == S_RD_ADDR) || (state == S_MV_RD);
    raddr = (state == S_RD_ADDR) ? pos : ptr;
    wen   = (state == S_MV_WR) || (state == S_PUT);
    waddr = (state == S_PUT) ? pos : dst;
    wdata = (state == S_PUT) ? cur.data_in : rdata;
  end

  ils_ram #(
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= req;
            status <= ST_OK;
            result <= '0;
            state  <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          case (cur.op)
            OP_INSERT: begin
              if (!empty_head && !in_range) begin
                status <= ST_RANGE;
                state  <= S_RESP;
              end else if (full) begin
                status <= ST_FULL;
                state  <= S_RESP;
              end else if (empty_head) begin
                pos   <= '0;
                state <= S_PUT;
              end else begin
                // open a gap: move from the tail down to the target
                pos   <= loc_pos;
                ptr   <= PW'(cnt_w - COUNT_W'(1));
                state <= S_MV_RD;
              end
            end
            OP_APPEND: begin
              if (full) begin
                status <= ST_FULL;
                state  <= S_RESP;
              end else begin
                pos   <= PW'(cnt_w);
                state <= S_PUT;
              end
            end
            default: begin
              if (!in_range) begin
                status <= ST_RANGE;
                state  <= S_RESP;
              end else begin
                pos   <= loc_pos;
                state <= S_RD_ADDR;
              end
            end
          endcase
        end
        S_RD_ADDR: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          result <= rdata;
          if (cur.op == OP_REMOVE) begin
            if (pos_has_succ) begin
              ptr   <= pos + PW'(1);
              state <= S_MV_RD;
            end else begin
              cnt   <= cnt - CW'(1);
              state <= S_RESP;
            end
          end else begin
            state <= S_RESP;
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          if (cur.op == OP_REMOVE) begin
            if (ptr_last) begin
              cnt   <= cnt - CW'(1);
              state <= S_RESP;
            end else begin
              ptr   <= ptr + PW'(1);
              state <= S_MV_RD;
            end
          end else begin
            if (ptr == pos) begin
              state <= S_PUT;
            end else begin
              ptr   <= ptr - PW'(1);
              state <= S_MV_RD;
            end
          end
        end
        S_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = state != S_IDLE;
  assign done         = state == S_RESP;
  assign rsp.status   = status;
  assign rsp.data_out = result;
  assign rsp.count    = COUNT_W'(cnt);

endmodule

// File: hdl/ils_check.sv
// Port-level checks for the indexed list store, bound to the top level.
module ils_check #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input ils_pkg::rsp_t rsp
);
  import ils_pkg::*;

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while not busy");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not raise busy");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ST_OK)) |-> (rsp.data_out == '0))
    else $error("failed request returned data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind indexed_list_store_top ils_check #(
  .CAPACITY(CAPACITY)
) u_ils_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the indexed list store: directed edge cases, then biased random traffic.
module tb;
  import ils_pkg::*;

  localparam int LIST_CAP       = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  indexed_list_store_top #(.CAPACITY(LIST_CAP)) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  // Shadow copy of the list, updated when a request transfers
  logic [WORD_WIDTH-1:0] list_words [LIST_CAP];
  int                    list_count;
  rsp_t                  pending_rsp [$];
  int                    mismatches;
  int                    idle_cycles;
  bit                    gaps_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rsp_t apply_list_op(req_t r);
    rsp_t res;
    int   pos;
    bit   hit;
    res.status   = ST_OK;
    res.data_out = '0;
    pos = 0;
    hit = (r.index < list_count);
    if (hit)
      pos = r.from_end ? (list_count - 1 - r.index) : r.index;
    case (r.op)
      OP_INSERT: begin
        // Head slot is legal even on an empty list, from either end
        if (r.index == 0 && list_count == 0) begin
          pos = 0;
          hit = 1'b1;
        end
        if (!hit) res.status = ST_RANGE;
        else if (list_count >= LIST_CAP) res.status = ST_FULL;
        else begin
          for (int i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = r.data_in;
          list_count++;
        end
      end
      OP_APPEND: begin
        if (list_count >= LIST_CAP) res.status = ST_FULL;
        else begin
          list_words[list_count] = r.data_in;
          list_count++;
        end
      end
      OP_READ: begin
        if (!hit) res.status = ST_RANGE;
        else res.data_out = list_words[pos];
      end
      default: begin
        if (!hit) res.status = ST_RANGE;
        else begin
          res.data_out = list_words[pos];
          for (int i = pos; i < list_count - 1; i++) list_words[i] = list_words[i+1];
          list_count--;
        end
      end
    endcase
    res.count = COUNT_W'(list_count);
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t build_req(logic [OP_W-1:0] op, logic from_end,
                                     logic [INDEX_W-1:0] index,
                                     logic [WORD_WIDTH-1:0] data_in);
    req_t r;
    r.op       = op;
    r.from_end = from_end;
    r.index    = index;
    r.data_in  = data_in;
    return r;
  endfunction

  // grow_pct: share of inserts and appends; stray_pct: share of indexes drawn over the full field
  function automatic req_t random_req(int grow_pct, int stray_pct);
    req_t r;
    int   roll;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) r.op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    else r.op = $urandom_range(0, 1) ? OP_READ : OP_REMOVE;
    r.from_end = 1'($urandom_range(0, 1));
    if (list_count == 0 || $urandom_range(0, 99) < stray_pct)
      r.index = INDEX_W'($urandom_range(0, 63));
    else
      r.index = INDEX_W'($urandom_range(0, list_count - 1));
    roll = $urandom_range(0, 99);
    if (roll < 8) r.data_in = '0;
    else if (roll < 16) r.data_in = '1;
    else r.data_in = $urandom;
    return r;
  endfunction

  // Hold start high across back-to-back transfers; drop it only for a gap
  task automatic send_request(req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_list_op(r));
  endtask

  task automatic run_random(int n, int grow_pct, int stray_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) gaps_on = ~gaps_on;
      send_request(random_req(grow_pct, stray_pct));
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    send_request(build_req(OP_READ,   1'b0, 6'd0,  32'h1111_1111));
    send_request(build_req(OP_REMOVE, 1'b0, 6'd0,  32'h0));
    send_request(build_req(OP_REMOVE, 1'b1, 6'd0,  32'h0));
    send_request(build_req(OP_INSERT, 1'b0, 6'd1,  32'hDEAD_BEEF));
    send_request(build_req(OP_INSERT, 1'b1, 6'd0,  32'h0000_0000));
    send_request(build_req(OP_INSERT, 1'b0, 6'd0,  32'hFFFF_FFFF));
    send_request(build_req(OP_APPEND, 1'b1, 6'd63, 32'h5A5A_A5A5));
    send_request(build_req(OP_INSERT, 1'b1, 6'd0,  32'h8000_0001));
    send_request(build_req(OP_INSERT, 1'b0, 6'd2,  32'h1234_5678));
    send_request(build_req(OP_INSERT, 1'b0, 6'd63, 32'hCAFE_F00D));
    send_request(build_req(OP_INSERT, 1'b1, 6'd5,  32'hCAFE_F00D));
    gaps_on = 1'b1;
    send_request(build_req(OP_READ,   1'b0, 6'd0,  32'h0));
    send_request(build_req(OP_READ,   1'b1, 6'd0,  32'h0));
    send_request(build_req(OP_READ,   1'b0, 6'd4,  32'h0));
    send_request(build_req(OP_READ,   1'b0, 6'd63, 32'h0));
    send_request(build_req(OP_READ,   1'b1, 6'd63, 32'h0));
    send_request(build_req(OP_REMOVE, 1'b0, 6'd1,  32'h0));
    send_request(build_req(OP_REMOVE, 1'b1, 6'd0,  32'h0));
    send_request(build_req(OP_REMOVE, 1'b1, 6'd5,  32'h0));
    send_request(build_req(OP_REMOVE, 1'b0, 6'd0,  32'h0));
    send_request(build_req(OP_REMOVE, 1'b1, 6'd0,  32'h0));
    send_request(build_req(OP_READ,   1'b0, 6'd0,  32'h0));
  endtask

  // Push the list to capacity and keep hitting the full condition
  task automatic test_fill_and_overflow();
    gaps_on = 1'b1;
    run_random(220, 90, 5);
    while (list_count < LIST_CAP) send_request(random_req(100, 0));
    send_request(build_req(OP_APPEND, 1'b0, 6'd0,  32'hFFFF_FFFF));
    send_request(build_req(OP_INSERT, 1'b0, 6'd0,  32'h0));
    send_request(build_req(OP_INSERT, 1'b1, 6'd63, 32'h0));
    send_request(build_req(OP_READ,   1'b0, 6'd63, 32'h0));
    send_request(build_req(OP_READ,   1'b1, 6'd63, 32'h0));
  endtask

  task automatic test_drain_to_empty();
    run_random(220, 12, 10);
    while (list_count > 0) send_request(random_req(0, 0));
    run_random(30, 40, 30);
  endtask

  task automatic test_mixed_traffic();
    run_random(400, 50, 15);
    run_random(300, 65, 25);
    run_random(300, 35, 25);
    run_random(300, 55, 10);
  endtask

  // Result checker: done is a one-cycle strobe, so sample it at every edge
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no request outstanding: status %0d data %h count %0d",
               rsp.status, rsp.data_out, rsp.count);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, rsp.data_out);
          mismatches++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp.count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: no transfer on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    list_count  = 0;
    mismatches  = 0;
    idle_cycles = 0;
    gaps_on     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_overflow();
    test_drain_to_empty();
    test_mixed_traffic();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ils_pkg.sv
hdl/ils_ram.sv
hdl/indexed_list_store_top.sv
hdl/ils_check.sv
sim/tb.sv
